// ===== sv/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// Depends on nothing; used by the channel interfaces, controller, datapath and top level.
package lr_pkg;

    localparam int COORD_W    = 14;
    localparam int DEPTH_W    = 15;
    localparam int PITCH_W    = 14;
    localparam int OFFS_W     = 20;
    localparam int ADDR_W     = 32;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // y*pitch fits 28 bits signed; one spare bit
    localparam int YBASE_W = 29;
    // Bresenham error term, covers +/- twice the largest span
    localparam int ERR_W   = 17;
    // |depth|*0xFFFF/10 fits 28 bits
    localparam int SHADE_W = 28;

    // 0xFFFF/10 = 6553 remainder 5, so n*0xFFFF/10 = n*6553 + n/2 exactly
    localparam int SHADE_MUL = 6553;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DEPTH_W-1:0] t_depth;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    localparam t_cfg_idx REG_ROW_PITCH     = 2'd0;
    localparam t_cfg_idx REG_BASE_COLOR    = 2'd1;
    localparam t_cfg_idx REG_ORIGIN_OFFSET = 2'd2;

    localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 14'd1024;
    localparam logic [COLOR_W-1:0] BASE_COLOR_RST    = 32'h00FF_FFFF;
    localparam logic [OFFS_W-1:0]  ORIGIN_OFFSET_RST = 20'd135300;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a request
        logic setup;  // derive spans, steps, row base and shade
        logic step;   // emit one pixel and advance the walk
    } t_lr_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;      // current pixel is the final one of the line
        logic out_room;  // output register can take a pixel this cycle
    } t_lr_sts;

endpackage

// ===== sv/lr_req_if.sv =====
// Line request channel: valid/ready handshake with end points and depth.
// Depends on lr_pkg for the field types.
interface lr_req_if;
    logic          valid;
    logic          ready;
    lr_pkg::t_coord x_start;
    lr_pkg::t_coord y_start;
    lr_pkg::t_coord x_end;
    lr_pkg::t_coord y_end;
    lr_pkg::t_depth depth;

    modport source (output valid, output x_start, output y_start, output x_end,
                    output y_end, output depth, input ready);
    modport sink   (input valid, input x_start, input y_start, input x_end,
                    input y_end, input depth, output ready);
endinterface

// ===== sv/lr_pix_if.sv =====
// Pixel result channel: valid/ready handshake with address, color and flags.
// Depends on lr_pkg for the field widths.
interface lr_pix_if;
    logic                               valid;
    logic                               ready;
    logic signed [lr_pkg::ADDR_W-1:0]   pixel_address;
    logic        [lr_pkg::COLOR_W-1:0]  pixel_color;
    logic                               write_enable;
    logic                               last_pixel;
    logic                               clipped;

    modport source (output valid, output pixel_address, output pixel_color,
                    output write_enable, output last_pixel, output clipped, input ready);
    modport sink   (input valid, input pixel_address, input pixel_color,
                    input write_enable, input last_pixel, input clipped, output ready);
endinterface

// ===== sv/lr_ctrl.sv =====
// Line rasterizer controller: request handshake and walk sequencing.
// Depends on lr_pkg for the command and status structs.
module lr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  lr_pkg::t_lr_sts i_sts,
    output lr_pkg::t_lr_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                // hold while the output register is full and not being drained
                if (i_sts.out_room) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/lr_dp.sv =====
// Line rasterizer datapath: configuration registers, Bresenham walker,
// address and shade arithmetic, output register. Depends on lr_pkg.
module lr_dp #(
    parameter int MAX_SPAN = 63
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  lr_pkg::t_cfg_idx                      i_cfg_idx,
    input  logic [lr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  lr_pkg::t_coord                        i_x_start,
    input  lr_pkg::t_coord                        i_y_start,
    input  lr_pkg::t_coord                        i_x_end,
    input  lr_pkg::t_coord                        i_y_end,
    input  lr_pkg::t_depth                        i_depth,
    input  lr_pkg::t_lr_cmd                       i_cmd,
    output lr_pkg::t_lr_sts                       o_sts,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [lr_pkg::ADDR_W-1:0]      o_pixel_address,
    output logic        [lr_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic                                  o_write_enable,
    output logic                                  o_last_pixel,
    output logic                                  o_clipped
);

    localparam int CW = (MAX_SPAN < 2) ? 1 : $clog2(MAX_SPAN + 1);
    localparam int CORD_W = lr_pkg::COORD_W;
    localparam int WSUM_W = lr_pkg::OFFS_W + 2;

    // configuration
    logic [lr_pkg::PITCH_W-1:0]  r_row_pitch;
    logic [lr_pkg::COLOR_W-1:0]  r_base_color;
    logic [lr_pkg::OFFS_W-1:0]   r_origin_offset;

    // request and walk state
    lr_pkg::t_coord               r_x;
    lr_pkg::t_coord               r_y;
    lr_pkg::t_coord               r_xe;
    lr_pkg::t_coord               r_ye;
    lr_pkg::t_depth               r_z;
    logic                         r_zneg;
    logic [CORD_W-1:0]            r_major;
    logic [CORD_W-1:0]            r_minor;
    logic                         r_xmajor;
    logic                         r_sx_neg;
    logic                         r_sy_neg;
    logic                         r_clip;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_last_idx;
    logic signed [lr_pkg::ERR_W-1:0]   r_err;
    logic signed [lr_pkg::YBASE_W-1:0] r_ybase;
    logic [lr_pkg::SHADE_W-1:0]   r_shade;

    // output register
    logic                         r_ovalid;
    logic signed [lr_pkg::ADDR_W-1:0] r_o_addr;
    logic [lr_pkg::COLOR_W-1:0]   r_o_color;
    logic                         r_o_we;
    logic                         r_o_last;
    logic                         r_o_clip;

    // setup terms
    logic signed [CORD_W:0]       w_dx;
    logic signed [CORD_W:0]       w_dy;
    logic [CORD_W-1:0]            w_ex;
    logic [CORD_W-1:0]            w_ey;
    logic                         w_xmajor;
    logic [CORD_W-1:0]            w_span;
    logic                         w_clip;
    logic signed [CORD_W:0]       w_pitch_s;
    logic [lr_pkg::DEPTH_W-1:0]   w_az;

    // walk terms
    logic signed [lr_pkg::ERR_W-1:0]   w_e1;
    logic signed [lr_pkg::ERR_W-1:0]   w_e2;
    logic                         w_minor_step;
    logic                         w_x_moves;
    logic                         w_y_moves;
    logic signed [lr_pkg::YBASE_W-1:0] w_pitch_yb;
    logic signed [WSUM_W-1:0]     w_wsum;
    logic                         w_last;

    assign w_dx = {r_xe[CORD_W-1], r_xe} - {r_x[CORD_W-1], r_x};
    assign w_dy = {r_ye[CORD_W-1], r_ye} - {r_y[CORD_W-1], r_y};
    assign w_ex = w_dx[CORD_W] ? CORD_W'(-w_dx) : w_dx[CORD_W-1:0];
    assign w_ey = w_dy[CORD_W] ? CORD_W'(-w_dy) : w_dy[CORD_W-1:0];
    assign w_xmajor = (w_ex >= w_ey);
    assign w_span   = w_xmajor ? w_ex : w_ey;
    assign w_clip   = (w_span > CORD_W'(MAX_SPAN));
    assign w_pitch_s = {1'b0, r_row_pitch};
    assign w_az = r_z[lr_pkg::DEPTH_W-1] ? lr_pkg::DEPTH_W'(-r_z) : r_z;

    assign w_e1 = r_err - {2'b00, r_minor, 1'b0};
    assign w_minor_step = w_e1[lr_pkg::ERR_W-1];
    assign w_e2 = w_minor_step ? (w_e1 + {2'b00, r_major, 1'b0}) : w_e1;
    assign w_x_moves = r_xmajor | w_minor_step;
    assign w_y_moves = !r_xmajor | w_minor_step;
    assign w_pitch_yb = lr_pkg::YBASE_W'({1'b0, r_row_pitch});
    assign w_wsum = WSUM_W'(r_x) + WSUM_W'(r_y) + WSUM_W'(r_origin_offset);
    assign w_last = (r_cnt == r_last_idx);

    assign o_sts.last     = w_last;
    assign o_sts.out_room = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pitch     <= lr_pkg::ROW_PITCH_RST;
            r_base_color    <= lr_pkg::BASE_COLOR_RST;
            r_origin_offset <= lr_pkg::ORIGIN_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lr_pkg::REG_ROW_PITCH: begin
                    r_row_pitch <= i_cfg_data[lr_pkg::PITCH_W-1:0];
                end
                lr_pkg::REG_BASE_COLOR: begin
                    r_base_color <= i_cfg_data[lr_pkg::COLOR_W-1:0];
                end
                lr_pkg::REG_ORIGIN_OFFSET: begin
                    r_origin_offset <= i_cfg_data[lr_pkg::OFFS_W-1:0];
                end
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_x_start;
            r_y  <= i_y_start;
            r_xe <= i_x_end;
            r_ye <= i_y_end;
            r_z  <= i_depth;
        end else if (i_cmd.setup) begin
            r_zneg     <= r_z[lr_pkg::DEPTH_W-1];
            r_xmajor   <= w_xmajor;
            r_major    <= w_span;
            r_minor    <= w_xmajor ? w_ey : w_ex;
            r_sx_neg   <= w_dx[CORD_W] || (w_dx == '0);
            r_sy_neg   <= w_dy[CORD_W] || (w_dy == '0);
            r_clip     <= w_clip;
            r_cnt      <= '0;
            r_last_idx <= w_clip ? CW'(MAX_SPAN) : w_span[CW-1:0];
            r_err      <= lr_pkg::ERR_W'(w_span);
            r_ybase    <= r_y * w_pitch_s;
            r_shade    <= lr_pkg::SHADE_W'(w_az) * lr_pkg::SHADE_W'(lr_pkg::SHADE_MUL)
                          + lr_pkg::SHADE_W'(w_az >> 1);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CW'(1);
            r_err <= w_e2;
            if (w_x_moves) begin
                r_x <= r_sx_neg ? (r_x - CORD_W'(1)) : (r_x + CORD_W'(1));
            end
            if (w_y_moves) begin
                r_y     <= r_sy_neg ? (r_y - CORD_W'(1)) : (r_y + CORD_W'(1));
                r_ybase <= r_sy_neg ? (r_ybase - w_pitch_yb) : (r_ybase + w_pitch_yb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.step) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_o_addr  <= lr_pkg::ADDR_W'(r_x) + lr_pkg::ADDR_W'(r_origin_offset)
                         + lr_pkg::ADDR_W'(r_ybase);
            // shade is truncated toward zero, so apply it by the depth sign
            r_o_color <= r_zneg ? (r_base_color + lr_pkg::COLOR_W'(r_shade))
                                : (r_base_color - lr_pkg::COLOR_W'(r_shade));
            r_o_we    <= !w_wsum[WSUM_W-1];
            r_o_last  <= w_last;
            r_o_clip  <= w_last && r_clip;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_write_enable  = r_o_we;
    assign o_last_pixel    = r_o_last;
    assign o_clipped       = r_o_clip;

endmodule

// ===== sv/line_rasterizer_top.sv =====
// Line rasterizer top level: controller plus datapath behind two handshake channels.
// Depends on lr_pkg, lr_req_if, lr_pix_if, lr_ctrl and lr_dp.
//
//   channel   | dir | handshake      | carries
//   ----------+-----+----------------+------------------------------------------------
//   i_req     | in  | valid/ready    | x_start, y_start, x_end, y_end, depth
//   o_pix     | out | valid/ready    | pixel_address, pixel_color, write_enable,
//             |     |                | last_pixel, clipped
//   i_cfg_*   | in  | write enable   | row_pitch, base_color, origin_offset by index
//
// A request is captured, then set up (two multipliers: y times pitch and the depth
// shade), then walked one pixel per cycle while the output register has room.
// The walker advances only when the output register is empty or being drained,
// so a stalled sink holds the walk. Requests are taken only between lines.
// Reset is synchronous: configuration returns to its defaults, no request is active.
module line_rasterizer_top #(
    parameter int MAX_SPAN = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lr_req_if.sink                            i_req,
    lr_pix_if.source                          o_pix
);

    lr_pkg::t_lr_cmd w_cmd;
    lr_pkg::t_lr_sts w_sts;
    logic            w_req_ready;

    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    lr_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_x_start       (i_req.x_start),
        .i_y_start       (i_req.y_start),
        .i_x_end         (i_req.x_end),
        .i_y_end         (i_req.y_end),
        .i_depth         (i_req.depth),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (o_pix.ready),
        .o_out_valid     (o_pix.valid),
        .o_pixel_address (o_pix.pixel_address),
        .o_pixel_color   (o_pix.pixel_color),
        .o_write_enable  (o_pix.write_enable),
        .o_last_pixel    (o_pix.last_pixel),
        .o_clipped       (o_pix.clipped)
    );

endmodule
